@@ rtl/segx_pkg.sv @@
// ----------------------------------------------------------------------------
// segx_pkg: shared widths and codes for the segment intersection pipeline
// Holds the coordinate width, the widths that follow from it and the status
// codes used by the interfaces and the datapath modules.
// ----------------------------------------------------------------------------
package segx_pkg;

	// Coordinate width and the widths of the line-equation terms.
	localparam int COORD_WIDTH = 16;
	localparam int CW  = COORD_WIDTH;
	localparam int LW  = CW + 1;          // line coefficients a and b
	localparam int PW  = 2 * CW;          // coordinate products
	localparam int CPW = 2 * CW + 1;      // line constant c
	localparam int TW  = 2 * CW + 1;      // coefficient times coordinate
	localparam int SW  = 2 * CW + 3;      // side value
	localparam int DDW = 2 * CW + 2;      // denominator partial products
	localparam int DW  = 2 * CW + 3;      // denominator
	localparam int UW  = LW + CPW;        // numerator partial products
	localparam int NW  = 3 * CW + 3;      // numerator
	localparam int QB  = CW + 1;          // quotient magnitude bits
	localparam int MW  = DW + QB;         // dividend magnitude
	localparam int BPS = 2;               // quotient bits resolved per stage
	localparam int NDS = (QB + BPS - 1) / BPS;
	localparam int DIV_LAT = NDS + 2;     // register depth of the divider

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_HIT  = 2'd1,
		ST_COLL = 2'd2
	} status_t;

endpackage

@@ rtl/segx_in_if.sv @@
// ----------------------------------------------------------------------------
// segx_in_if: segment pair channel
// Carries two segments, each as two endpoints, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface segx_in_if import segx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] ax0;
	logic signed [CW-1:0] ay0;
	logic signed [CW-1:0] ax1;
	logic signed [CW-1:0] ay1;
	logic signed [CW-1:0] bx0;
	logic signed [CW-1:0] by0;
	logic signed [CW-1:0] bx1;
	logic signed [CW-1:0] by1;

	modport source (output valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, input ready);
	modport sink   (input valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, output ready);
endinterface

@@ rtl/segx_out_if.sv @@
// ----------------------------------------------------------------------------
// segx_out_if: intersection result channel
// Carries the status code and the rounded intersection point.
// ----------------------------------------------------------------------------
interface segx_out_if import segx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;

	modport source (output valid, status, hit_x, hit_y, input ready);
	modport sink   (input valid, status, hit_x, hit_y, output ready);
endinterface

@@ rtl/segment_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_intersection: pipelined two-segment intersection test
//
//   Channel  Dir  Payload
//   req      in   ax0 ay0 ax1 ay1 bx0 by0 bx1 by1 (signed coordinates)
//   rsp      out  status, hit_x, hit_y
//
// One pair is taken every cycle unless the output holds; each result passes
// through the four equation stages and the two-bit-per-stage restoring divider.
// Reset clears the valid bits only. When the result at the output is not
// taken, the whole pipeline holds and req.ready falls in the same cycle.
// ----------------------------------------------------------------------------
module segment_intersection import segx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	segx_in_if.sink    req,
	segx_out_if.source rsp
);

	logic adv;

	// Stage 1 registers.
	logic                 vld_s1;
	logic signed [CW-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [LW-1:0] la_s1, lb_s1, ma_s1, mb_s1;
	logic signed [PW-1:0] p1_s1, p2_s1, p3_s1, p4_s1;

	// Stage 2 registers.
	logic                  vld_s2;
	logic signed [LW-1:0]  la_s2, lb_s2, ma_s2, mb_s2;
	logic signed [CPW-1:0] lc_s2, mc_s2;
	logic signed [TW-1:0]  a3_s2, b3_s2, a4_s2, b4_s2, c1_s2, d1_s2, c2_s2, d2_s2;
	logic signed [DDW-1:0] dd1_s2, dd2_s2;

	// Stage 3 registers.
	logic                 vld_s3;
	logic signed [SW-1:0] sb0_s3, sb1_s3, sa0_s3, sa1_s3;
	logic signed [DW-1:0] den_s3;
	logic signed [UW-1:0] u1_s3, u2_s3, u3_s3, u4_s3;

	// Stage 4 registers.
	logic                 vld_s4;
	status_t              st_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic signed [DW-1:0] den_s4;

	// Status line alongside the divider.
	logic    dvld_s [0:DIV_LAT-1];
	status_t dst_s  [0:DIV_LAT-1];

	logic signed [CW-1:0] qx, qy;

	function automatic logic same_side(logic signed [SW-1:0] s, logic signed [SW-1:0] t);
		return (s != '0) && (t != '0) && (s[SW-1] == t[SW-1]);
	endfunction

	// The pipeline moves whenever the output register is free or drained.
	assign adv       = !dvld_s[DIV_LAT-1] || rsp.ready;
	assign req.ready = adv;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++)
				dvld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s1    <= req.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			dvld_s[0] <= vld_s4;
			for (int i = 1; i < DIV_LAT; i++)
				dvld_s[i] <= dvld_s[i-1];
		end
	end

	// Stage 1: coefficients and the coordinate products of the constants.
	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= req.ax0;
			y1_s1 <= req.ay0;
			x2_s1 <= req.ax1;
			y2_s1 <= req.ay1;
			x3_s1 <= req.bx0;
			y3_s1 <= req.by0;
			x4_s1 <= req.bx1;
			y4_s1 <= req.by1;
			la_s1 <= LW'(req.ay1) - LW'(req.ay0);
			lb_s1 <= LW'(req.ax0) - LW'(req.ax1);
			ma_s1 <= LW'(req.by1) - LW'(req.by0);
			mb_s1 <= LW'(req.bx0) - LW'(req.bx1);
			p1_s1 <= PW'(req.ax1) * PW'(req.ay0);
			p2_s1 <= PW'(req.ax0) * PW'(req.ay1);
			p3_s1 <= PW'(req.bx1) * PW'(req.by0);
			p4_s1 <= PW'(req.bx0) * PW'(req.by1);
		end
	end

	// Stage 2: line constants and the side-test and denominator products.
	always_ff @(posedge clk) begin
		if (adv) begin
			la_s2  <= la_s1;
			lb_s2  <= lb_s1;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
			lc_s2  <= CPW'(p1_s1) - CPW'(p2_s1);
			mc_s2  <= CPW'(p3_s1) - CPW'(p4_s1);
			a3_s2  <= TW'(la_s1) * TW'(x3_s1);
			b3_s2  <= TW'(lb_s1) * TW'(y3_s1);
			a4_s2  <= TW'(la_s1) * TW'(x4_s1);
			b4_s2  <= TW'(lb_s1) * TW'(y4_s1);
			c1_s2  <= TW'(ma_s1) * TW'(x1_s1);
			d1_s2  <= TW'(mb_s1) * TW'(y1_s1);
			c2_s2  <= TW'(ma_s1) * TW'(x2_s1);
			d2_s2  <= TW'(mb_s1) * TW'(y2_s1);
			dd1_s2 <= DDW'(la_s1) * DDW'(mb_s1);
			dd2_s2 <= DDW'(ma_s1) * DDW'(lb_s1);
		end
	end

	// Stage 3: side values, denominator and the numerator products.
	always_ff @(posedge clk) begin
		if (adv) begin
			sb0_s3 <= SW'(a3_s2) + SW'(b3_s2) + SW'(lc_s2);
			sb1_s3 <= SW'(a4_s2) + SW'(b4_s2) + SW'(lc_s2);
			sa0_s3 <= SW'(c1_s2) + SW'(d1_s2) + SW'(mc_s2);
			sa1_s3 <= SW'(c2_s2) + SW'(d2_s2) + SW'(mc_s2);
			den_s3 <= DW'(dd1_s2) - DW'(dd2_s2);
			u1_s3  <= UW'(lb_s2) * UW'(mc_s2);
			u2_s3  <= UW'(mb_s2) * UW'(lc_s2);
			u3_s3  <= UW'(ma_s2) * UW'(lc_s2);
			u4_s3  <= UW'(la_s2) * UW'(mc_s2);
		end
	end

	// Stage 4: rejection, collinear check and the numerators.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (same_side(sb0_s3, sb1_s3) || same_side(sa0_s3, sa1_s3))
				st_s4 <= ST_NONE;
			else if (den_s3 == '0)
				st_s4 <= ST_COLL;
			else
				st_s4 <= ST_HIT;
			nx_s4  <= NW'(u1_s3) - NW'(u2_s3);
			ny_s4  <= NW'(u3_s3) - NW'(u4_s3);
			den_s4 <= den_s3;
		end
	end

	// Status travels beside the divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			dst_s[0] <= st_s4;
			for (int i = 1; i < DIV_LAT; i++)
				dst_s[i] <= dst_s[i-1];
		end
	end

	segx_div u_div_x (
		.clk    (clk),
		.en     (adv),
		.num    (nx_s4),
		.den    (den_s4),
		.quo    (qx)
	);

	segx_div u_div_y (
		.clk    (clk),
		.en     (adv),
		.num    (ny_s4),
		.den    (den_s4),
		.quo    (qy)
	);

	// Output: the point is shown only for an intersecting pair.
	assign rsp.valid  = dvld_s[DIV_LAT-1];
	assign rsp.status = dst_s[DIV_LAT-1];
	assign rsp.hit_x  = (dst_s[DIV_LAT-1] == ST_HIT) ? qx : '0;
	assign rsp.hit_y  = (dst_s[DIV_LAT-1] == ST_HIT) ? qy : '0;

endmodule

@@ rtl/segx_div.sv @@
// ----------------------------------------------------------------------------
// segx_div: pipelined rounding divider
// Adds the signed half-denominator offset, divides with truncation toward
// zero by restoring division, two quotient bits per stage, and saturates.
// ----------------------------------------------------------------------------
module segx_div import segx_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic signed [CW-1:0] quo
);

	logic [DW-1:0]        dabs;
	logic signed [MW-1:0] nsum;
	logic [MW-1:0]        nmag;

	logic [MW-1:0] rem_s  [0:NDS];
	logic [DW-1:0] dmag_s [0:NDS];
	logic [QB-1:0] q_s    [0:NDS];
	logic          neg_s  [0:NDS];
	logic          ovf_s  [0:NDS];
	logic [MW-1:0] rem_nx [0:NDS-1];
	logic [QB-1:0] q_nx   [0:NDS-1];
	logic          ovf_nx [0:NDS-1];
	logic signed [CW-1:0] quo_nx;

	// Rounding offset and magnitudes of the operands.
	always_comb begin
		dabs = den[DW-1] ? DW'(-den) : DW'(den);
		if (num[NW-1])
			nsum = MW'(num) - MW'(signed'({1'b0, dabs[DW-1:1]}));
		else
			nsum = MW'(num) + MW'(signed'({1'b0, dabs[DW-1:1]}));
		nmag = nsum[MW-1] ? MW'(-nsum) : MW'(nsum);
	end

	// Entry register of the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= nmag;
			dmag_s[0] <= dabs;
			q_s[0]    <= '0;
			neg_s[0]  <= nsum[MW-1] ^ den[DW-1];
			ovf_s[0]  <= 1'b0;
		end
	end

	// Restoring division stages, most significant quotient bits first.
	for (genvar k = 0; k < NDS; k++) begin : g_stage
		always_comb begin
			logic [MW-1:0] r;
			logic [MW-1:0] t;
			logic [QB-1:0] q;
			int            bi;
			r  = rem_s[k];
			q  = q_s[k];
			for (int j = 0; j < BPS; j++) begin
				bi = QB - 1 - k * BPS - j;
				if (bi >= 0) begin
					t = MW'(dmag_s[k]) << bi;
					if (r >= t) begin
						r     = r - t;
						q[bi] = 1'b1;
					end
				end
			end
			rem_nx[k] = r;
			q_nx[k]   = q;
			if (k == 0)
				ovf_nx[k] = rem_s[0] >= (MW'(dmag_s[0]) << QB);
			else
				ovf_nx[k] = ovf_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx[k];
				q_s[k+1]    <= q_nx[k];
				dmag_s[k+1] <= dmag_s[k];
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_nx[k];
			end
		end
	end

	// Apply the sign and saturate to the coordinate range.
	always_comb begin
		if (neg_s[NDS]) begin
			if (ovf_s[NDS] || (q_s[NDS] > QB'({1'b0, CMIN})))
				quo_nx = CMIN;
			else
				quo_nx = CW'(-q_s[NDS]);
		end else begin
			if (ovf_s[NDS] || (q_s[NDS] > QB'(CMAX)))
				quo_nx = CMAX;
			else
				quo_nx = CW'(q_s[NDS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			quo <= quo_nx;
	end

endmodule

@@ tb/tb_segment_intersection.sv @@
// ----------------------------------------------------------------------------
// tb_segment_intersection: self-checking bench for the segment intersection
// Drives segment pairs through the request channel with random gaps, predicts
// status and rounded hit point for each transfer, and checks every response
// in order while the response side stalls at random.
// ----------------------------------------------------------------------------
module tb_segment_intersection;
	import segx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	} seg_pair_t;

	typedef struct {
		status_t status;
		coord_t  hit_x;
		coord_t  hit_y;
	} hit_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 4 + DIV_LAT + 10;

	logic clk;
	logic arst_n;

	segx_in_if  req();
	segx_out_if rsp();

	segment_intersection dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	seg_pair_t pending_pairs[$];
	hit_t      expected_hits[$];
	int        mismatches;
	int        sent_pairs;
	int        checked_hits;
	int        hit_count, miss_count, coll_count;
	int        idle_cycles;
	bit        hold_rsp;
	bit        hold_req;
	int        req_gap;
	int        rsp_gap;
	int        rsp_draw;
	bit        req_fire;
	bit        rsp_fire;

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clamp a wide value to the signed coordinate range.
	function automatic coord_t clamp_to_coord(longint v);
		if (v > longint'(CMAX))
			return CMAX;
		if (v < longint'(CMIN))
			return CMIN;
		return coord_t'(v);
	endfunction

	// True when both side values are non-zero and of the same sign.
	function automatic bit same_side_strict(longint s, longint t);
		return s != 0 && t != 0 && ((s > 0) == (t > 0));
	endfunction

	// Rounded division: half the denominator magnitude added away from zero.
	function automatic longint div_rounded(longint num, longint den);
		longint off;
		off = (den < 0 ? -den : den) / 2;
		return ((num < 0) ? num - off : num + off) / den;
	endfunction

	// Predict the intersection result of one segment pair.
	function automatic hit_t predict_intersection(seg_pair_t p);
		hit_t   r;
		longint x1, y1, x2, y2, x3, y3, x4, y4;
		longint la, lb, lc, ma, mb, mc, den;
		x1 = p.ax0; y1 = p.ay0; x2 = p.ax1; y2 = p.ay1;
		x3 = p.bx0; y3 = p.by0; x4 = p.bx1; y4 = p.by1;
		r.status = ST_NONE;
		r.hit_x  = '0;
		r.hit_y  = '0;
		la = y2 - y1;
		lb = x1 - x2;
		lc = x2 * y1 - x1 * y2;
		if (same_side_strict(la * x3 + lb * y3 + lc, la * x4 + lb * y4 + lc))
			return r;
		ma = y4 - y3;
		mb = x3 - x4;
		mc = x4 * y3 - x3 * y4;
		if (same_side_strict(ma * x1 + mb * y1 + mc, ma * x2 + mb * y2 + mc))
			return r;
		den = la * mb - ma * lb;
		if (den == 0) begin
			r.status = ST_COLL;
			return r;
		end
		r.status = ST_HIT;
		r.hit_x  = clamp_to_coord(div_rounded(lb * mc - mb * lc, den));
		r.hit_y  = clamp_to_coord(div_rounded(ma * lc - la * mc, den));
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic queue_pair(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
			coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
		seg_pair_t p;
		p = '{ax0, ay0, ax1, ay1, bx0, by0, bx1, by1};
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	// Random coordinate: mostly small, sometimes full range or an extreme.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
			1, 2, 3: return coord_t'($urandom);
			default: return coord_t'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	// Random pair that mostly crosses: two segments centred near a common point.
	task automatic queue_random_pair();
		coord_t cx, cy;
		int     dx, dy, ex, ey;
		if ($urandom_range(0, 3) == 0) begin
			queue_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord());
		end else begin
			cx = coord_t'($signed($urandom_range(0, 40000)) - 20000);
			cy = coord_t'($signed($urandom_range(0, 40000)) - 20000);
			dx = $signed($urandom_range(0, 12000)) - 6000;
			dy = $signed($urandom_range(0, 12000)) - 6000;
			ex = $signed($urandom_range(0, 12000)) - 6000;
			ey = $signed($urandom_range(0, 12000)) - 6000;
			if ($urandom_range(0, 7) == 0) begin
				// Nearly parallel: same offsets as the first segment.
				ex = dx;
				ey = dy;
			end
			queue_pair(coord_t'(cx - dx), coord_t'(cy - dy),
				coord_t'(cx + dx), coord_t'(cy + dy),
				coord_t'(cx - ex + 3), coord_t'(cy - ey),
				coord_t'(cx + ex), coord_t'(cy + ey - 2));
		end
	endtask

	// Transfers seen at the rising edge, for the processes at the falling edge.
	always @(posedge clk) begin
		req_fire <= arst_n && req.valid && req.ready;
		rsp_fire <= arst_n && rsp.valid && rsp.ready;
	end

	// Sender: holds a pair until it transfers, then waits its drawn gap.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			{req.ax0, req.ay0, req.ax1, req.ay1} <= '0;
			{req.bx0, req.by0, req.bx1, req.by1} <= '0;
			req_gap <= 0;
		end else if (req.valid && !req_fire) begin
			// The offered pair stays on the bus until it is taken.
		end else if (req_gap > 0) begin
			req.valid <= 1'b0;
			req_gap   <= req_gap - 1;
		end else if (!hold_req && pending_pairs.size() > 0) begin
			seg_pair_t p;
			p = pending_pairs.pop_front();
			{req.ax0, req.ay0, req.ax1, req.ay1} <= {p.ax0, p.ay0, p.ax1, p.ay1};
			{req.bx0, req.by0, req.bx1, req.by1} <= {p.bx0, p.by0, p.bx1, p.by1};
			req.valid <= 1'b1;
			req_gap   <= $urandom_range(0, 4);
		end else begin
			req.valid <= 1'b0;
		end
	end

	// Receiver: after each transfer, ready drops for a randomly drawn gap.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_gap   <= 0;
		end else if (hold_rsp) begin
			rsp.ready <= 1'b0;
		end else if (rsp_fire) begin
			rsp_draw = $urandom_range(0, 4);
			rsp.ready <= (rsp_draw == 0);
			rsp_gap   <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
		end else if (rsp_gap > 0) begin
			rsp_gap   <= rsp_gap - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Monitor: predict on request transfers, check on response transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_hits.insert(expected_hits.size(),
					predict_intersection('{req.ax0, req.ay0, req.ax1, req.ay1,
						req.bx0, req.by0, req.bx1, req.by1}));
				sent_pairs++;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("response with no pair outstanding");
				end else begin
					hit_t e;
					e = expected_hits.pop_front();
					if (rsp.status !== e.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							rsp.status, e.status));
					if (rsp.hit_x !== e.hit_x)
						report_mismatch($sformatf("hit_x %0d, predicted %0d",
							rsp.hit_x, e.hit_x));
					if (rsp.hit_y !== e.hit_y)
						report_mismatch($sformatf("hit_y %0d, predicted %0d",
							rsp.hit_y, e.hit_y));
					case (e.status)
						ST_HIT:  hit_count++;
						ST_COLL: coll_count++;
						default: miss_count++;
					endcase
				end
				checked_hits++;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d responses outstanding",
				expected_hits.size());
			$display("tb_segment_intersection NOT OK");
			$finish;
		end
	end

	// Long response stall while the sender keeps offering.
	initial begin
		hold_rsp = 1'b0;
		wait (sent_pairs >= 60);
		@(negedge clk);
		hold_rsp = 1'b1;
		repeat (60) @(negedge clk);
		hold_rsp = 1'b0;
	end

	// Stimulus and end of run.
	initial begin
		mismatches = 0;
		sent_pairs = 0;
		checked_hits = 0;
		hit_count = 0;
		miss_count = 0;
		coll_count = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: crossing, disjoint, touching, parallel, collinear, degenerate.
		queue_pair(0, 0, 10, 10, 0, 10, 10, 0);
		queue_pair(0, 0, 10, 0, 0, 5, 10, 5);
		queue_pair(0, 0, 10, 0, 5, 0, 5, 7);
		queue_pair(0, 0, 10, 0, 10, 0, 20, 5);
		queue_pair(0, 0, 10, 0, 5, 0, 15, 0);
		queue_pair(0, 0, 10, 0, 20, 0, 30, 0);
		queue_pair(3, 3, 3, 3, 3, 3, 3, 3);
		queue_pair(3, 3, 3, 3, 0, 0, 6, 6);
		queue_pair(0, 0, 3, 1, 0, 1, 3, 0);
		queue_pair(0, 0, -3, 1, 0, 1, -3, 0);
		queue_pair(0, 0, 7, 2, 1, 3, 5, -4);
		queue_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
		queue_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
		queue_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
		queue_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX - 1);
		queue_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		queue_pair(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
		queue_pair(-32768, 1, 32767, 2, 0, -32768, 1, 32767);
		queue_pair(-5, 0, 5, 1, 0, -5, 1, 5);
		queue_pair(0, 0, 5, 5, 5, 5, 9, 0);

		for (int i = 0; i < 200; i++)
			queue_random_pair();

		// Sender pause until every response has come back.
		wait (pending_pairs.size() == 0);
		hold_req = 1'b1;
		wait (expected_hits.size() == 0 && !req.valid);
		@(negedge clk);
		hold_req = 1'b0;

		for (int i = 0; i < 230; i++)
			queue_random_pair();

		wait (pending_pairs.size() == 0 && !req.valid);
		wait (expected_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses for %0d pairs: %0d hits, %0d misses, %0d collinear.",
			checked_hits, sent_pairs, hit_count, miss_count, coll_count);
		$display("Stimulus covered extreme coordinates, touching ends and degenerate segments.");
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("tb_segment_intersection OK");
		else
			$display("tb_segment_intersection NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/segx_pkg.sv
rtl/segx_in_if.sv
rtl/segx_out_if.sv
rtl/segx_div.sv
rtl/segment_intersection.sv
tb/tb_segment_intersection.sv
